FILE: src/tcw_pkg.sv
// Shared constants, types and codes of the text console writer.
package tcw_pkg;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELLS       = ROWS * COLUMNS;
  localparam int COPY_CELLS  = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W      = $clog2(CELLS);
  localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W       = $clog2(COLUMNS);
  localparam int POS_W       = 11;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'h20;

  typedef enum logic [1:0] {
    OP_READ,
    OP_NEWLINE,
    OP_CHAR
  } op_e;

  typedef enum logic [2:0] {
    ST_ZERO,
    ST_IDLE,
    ST_RDATA,
    ST_COPY,
    ST_BLANK,
    ST_RESULT
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [7:0]       code;
    logic [7:0]       attr;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             in_range;
  } cmd_t;

endpackage

FILE: src/text_console_writer.sv
// Top level of the text console writer: front end, command queue and screen engine.
// A 25 by 80 text screen of 16-bit cells (character low, attribute high) kept in one
// single-port-write, registered-read memory. After reset the engine clears the screen,
// one cell per cycle, and takes no item until that is done. Items are
// decoded and queued two deep, so the input keeps moving while a result waits. In the
// engine an on-screen read steps through IDLE, RDATA and RESULT, an off-screen read or a
// newline through IDLE and RESULT, and a printable character through IDLE (the character
// write), BLANK (the blank-cell write) and RESULT.
// A newline or a line wrap on the bottom row also scrolls the screen: rows are copied
// upward one cell per cycle, and then the bottom row is cleared.
module text_console_writer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       kind_i,
  input  logic [7:0]                 char_code_i,
  input  logic [7:0]                 attr_byte_i,
  input  logic [4:0]                 read_row_i,
  input  logic [6:0]                 read_col_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 cell_char_o,
  output logic [7:0]                 cell_attr_o,
  output logic [tcw_pkg::POS_W-1:0]  cursor_position_o
);

  tcw_pkg::cmd_t front_cmd, queue_cmd;
  logic          queue_valid, queue_pop;

  tcw_front u_front (
    .kind_i      (kind_i),
    .char_code_i (char_code_i),
    .attr_byte_i (attr_byte_i),
    .read_row_i  (read_row_i),
    .read_col_i  (read_col_i),
    .cmd_o       (front_cmd)
  );

  tcw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_stall_o (in_stall_o),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (queue_valid),
    .pop_i        (queue_pop),
    .pop_cmd_o    (queue_cmd)
  );

  tcw_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_valid_i       (queue_valid),
    .cmd_i             (queue_cmd),
    .cmd_pop_o         (queue_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .cell_char_o       (cell_char_o),
    .cell_attr_o       (cell_attr_o),
    .cursor_position_o (cursor_position_o)
  );

endmodule

FILE: src/tcw_front.sv
// Front end: classifies an incoming item into a console command.
module tcw_front (
  input  logic              kind_i,
  input  logic [7:0]        char_code_i,
  input  logic [7:0]        attr_byte_i,
  input  logic [4:0]        read_row_i,
  input  logic [6:0]        read_col_i,
  output tcw_pkg::cmd_t     cmd_o
);

  always_comb begin
    cmd_o.code     = char_code_i;
    cmd_o.attr     = attr_byte_i;
    cmd_o.row      = tcw_pkg::ROW_W'(read_row_i);
    cmd_o.col      = tcw_pkg::COL_W'(read_col_i);
    cmd_o.in_range = (int'(read_row_i) < tcw_pkg::ROWS) &&
                     (int'(read_col_i) < tcw_pkg::COLUMNS);
    if (kind_i) begin
      cmd_o.op = tcw_pkg::OP_READ;
    end else if (char_code_i == tcw_pkg::NEWLINE_CODE) begin
      cmd_o.op = tcw_pkg::OP_NEWLINE;
    end else begin
      cmd_o.op = tcw_pkg::OP_CHAR;
    end
  end

endmodule

FILE: src/tcw_queue.sv
// Short command queue between the front end and the screen engine.
module tcw_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_stall_o,
  input  tcw_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_i,
  output tcw_pkg::cmd_t pop_cmd_o
);

  logic [tcw_pkg::QCNT_W-1:0] count_q, count_d;
  logic [tcw_pkg::QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  tcw_pkg::cmd_t              entry_q [tcw_pkg::QUEUE_DEPTH];
  logic                       push, pop;

  assign push_stall_o = (count_q == tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i & ~push_stall_o;
  assign pop          = pop_i & pop_valid_o;
  assign pop_cmd_o    = entry_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = (int'(wptr_q) == tcw_pkg::QUEUE_DEPTH - 1) ? '0 :
               wptr_q + tcw_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rptr_d = (int'(rptr_q) == tcw_pkg::QUEUE_DEPTH - 1) ? '0 :
               rptr_q + tcw_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + tcw_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - tcw_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      wptr_q  <= '0;
      rptr_q  <= '0;
    end else begin
      count_q <= count_d;
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule

FILE: src/tcw_back.sv
// Screen engine: owns the cell memory and the cursor and carries out commands.
module tcw_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  tcw_pkg::cmd_t              cmd_i,
  output logic                       cmd_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 cell_char_o,
  output logic [7:0]                 cell_attr_o,
  output logic [tcw_pkg::POS_W-1:0]  cursor_position_o
);

  function automatic logic [tcw_pkg::ADDR_W-1:0] cell_addr(
    input logic [tcw_pkg::ROW_W-1:0] row,
    input logic [tcw_pkg::COL_W-1:0] col
  );
    cell_addr = tcw_pkg::ADDR_W'(int'(row) * tcw_pkg::COLUMNS + int'(col));
  endfunction

  tcw_pkg::state_e             state_q, state_d;
  tcw_pkg::cmd_t               cmd_q, cmd_d;
  logic                        init_q, init_d;
  logic [tcw_pkg::ADDR_W-1:0]  cnt_q, cnt_d;
  logic [tcw_pkg::ROW_W-1:0]   row_q, row_d;
  logic [tcw_pkg::COL_W-1:0]   col_q, col_d;
  logic [tcw_pkg::COL_W:0]     col_inc;
  logic [tcw_pkg::POS_W-1:0]   shown_q, shown_d;
  logic [7:0]                  res_char_q, res_char_d, res_attr_q, res_attr_d;
  logic                        out_valid_q, out_valid_d, out_load;
  logic [7:0]                  out_char_q, out_attr_q;
  logic [tcw_pkg::POS_W-1:0]   out_pos_q;
  logic                        last_row;
  logic [tcw_pkg::ADDR_W-1:0]  cur_addr;

  logic [15:0]                 mem [tcw_pkg::CELLS];
  logic [15:0]                 rd_q;
  logic [tcw_pkg::ADDR_W-1:0]  rd_addr, wr_addr;
  logic [15:0]                 wr_data;
  logic                        wr_en;

  assign cur_addr = cell_addr(row_q, col_q);
  assign last_row = (row_q == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
  assign col_inc  = {1'b0, col_q} + (tcw_pkg::COL_W + 1)'(1);
  assign out_load = (state_q == tcw_pkg::ST_RESULT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    init_d     = init_q;
    cnt_d      = cnt_q;
    row_d      = row_q;
    col_d      = col_q;
    shown_d    = shown_q;
    res_char_d = res_char_q;
    res_attr_d = res_attr_q;
    cmd_pop_o  = 1'b0;
    rd_addr    = cell_addr(cmd_i.row, cmd_i.col);
    wr_en      = 1'b0;
    wr_addr    = cur_addr;
    wr_data    = '0;
    unique case (state_q)
      tcw_pkg::ST_ZERO: begin
        wr_en   = 1'b1;
        wr_addr = cnt_q;
        cnt_d   = cnt_q + tcw_pkg::ADDR_W'(1);
        if (int'(cnt_q) == tcw_pkg::CELLS - 1) begin
          if (init_q) begin
            init_d  = 1'b0;
            state_d = tcw_pkg::ST_IDLE;
          end else if (cmd_q.op == tcw_pkg::OP_CHAR) begin
            state_d = tcw_pkg::ST_BLANK;
          end else begin
            state_d = tcw_pkg::ST_RESULT;
          end
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o  = 1'b1;
          cmd_d      = cmd_i;
          res_char_d = '0;
          res_attr_d = '0;
          cnt_d      = '0;
          unique case (cmd_i.op)
            tcw_pkg::OP_READ: begin
              state_d = cmd_i.in_range ? tcw_pkg::ST_RDATA : tcw_pkg::ST_RESULT;
            end
            tcw_pkg::OP_NEWLINE: begin
              col_d = '0;
              if (last_row) begin
                state_d = tcw_pkg::ST_COPY;
              end else begin
                row_d   = row_q + tcw_pkg::ROW_W'(1);
                state_d = tcw_pkg::ST_RESULT;
              end
            end
            tcw_pkg::OP_CHAR: begin
              wr_en   = 1'b1;
              wr_data = {cmd_i.attr, cmd_i.code};
              state_d = tcw_pkg::ST_BLANK;
              if (col_inc == (tcw_pkg::COL_W + 1)'(tcw_pkg::COLUMNS)) begin
                col_d = '0;
                if (last_row) begin
                  state_d = tcw_pkg::ST_COPY;
                end else begin
                  row_d = row_q + tcw_pkg::ROW_W'(1);
                end
              end else begin
                col_d = col_inc[tcw_pkg::COL_W-1:0];
              end
            end
            default: begin
              state_d = tcw_pkg::ST_RESULT;
            end
          endcase
        end
      end
      tcw_pkg::ST_RDATA: begin
        res_char_d = rd_q[7:0];
        res_attr_d = rd_q[15:8];
        state_d    = tcw_pkg::ST_RESULT;
      end
      tcw_pkg::ST_COPY: begin
        rd_addr = cnt_q + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
        wr_en   = (cnt_q != '0);
        wr_addr = cnt_q - tcw_pkg::ADDR_W'(1);
        wr_data = rd_q;
        if (int'(cnt_q) == tcw_pkg::COPY_CELLS) begin
          state_d = tcw_pkg::ST_ZERO;
        end else begin
          cnt_d = cnt_q + tcw_pkg::ADDR_W'(1);
        end
      end
      tcw_pkg::ST_BLANK: begin
        wr_en   = 1'b1;
        wr_data = {cmd_q.attr, tcw_pkg::SPACE_CODE};
        shown_d = tcw_pkg::POS_W'(cur_addr);
        state_d = tcw_pkg::ST_RESULT;
      end
      tcw_pkg::ST_RESULT: begin
        if (out_load) begin
          state_d = tcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::ST_ZERO;
      init_q      <= 1'b1;
      cnt_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      shown_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      cnt_q       <= cnt_d;
      row_q       <= row_d;
      col_q       <= col_d;
      shown_q     <= shown_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    res_char_q <= res_char_d;
    res_attr_q <= res_attr_d;
    if (out_load) begin
      out_char_q <= res_char_q;
      out_attr_q <= res_attr_q;
      out_pos_q  <= shown_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  assign out_valid_o       = out_valid_q;
  assign cell_char_o       = out_char_q;
  assign cell_attr_o       = out_attr_q;
  assign cursor_position_o = out_pos_q;

  a_copy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tcw_pkg::ST_COPY |-> int'(cnt_q) <= tcw_pkg::COPY_CELLS)
    else $error("scroll copy ran past the last row");

  a_blank_then_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tcw_pkg::ST_BLANK |=> state_q == tcw_pkg::ST_RESULT)
    else $error("blank cell write not followed by a result");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(row_q) < tcw_pkg::ROWS && int'(col_q) < tcw_pkg::COLUMNS)
    else $error("cursor left the screen");

  a_no_pop_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_q |-> !cmd_pop_o)
    else $error("command taken before the screen was cleared");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("result loaded but not presented");

endmodule
